FILE: hw/rtl/abss_pkg.sv
`default_nettype none

package abss_pkg;

  localparam int AXES      = 3;
  localparam int NUM_SLOTS = 2 * AXES;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  // coordinate plus size, plus sign headroom for exact ends
  localparam int WIDE_W    = COORD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         ext_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  // one axis-aligned box, axis 0 is x, axis 2 is z
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] corner;
    logic [AXES-1:0][SIZE_W-1:0]  ext;
  } box_t;

  typedef struct packed {
    box_t box;
    logic valid;
  } piece_t;

  // cuts made on one axis, and the working box left on that axis
  typedef struct packed {
    logic   lo_v;
    ext_t   lo_size;
    logic   hi_v;
    coord_t hi_min;
    ext_t   hi_size;
    coord_t fin_min;
    ext_t   fin_size;
    logic   stop;
  } axis_cut_t;

  // piece buffer status toward the input register
  typedef struct packed {
    logic take;
    logic busy;
  } emit_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/abss_axis_cut.sv
`default_nettype none

module abss_axis_cut (
  input  abss_pkg::coord_t    p0,
  input  abss_pkg::ext_t      s0,
  input  abss_pkg::coord_t    b_min,
  input  abss_pkg::ext_t      b_size,
  output abss_pkg::axis_cut_t cut
);

  abss_pkg::wide_t p0_w, s0_w, end_w, bmin_w, bend_w;
  abss_pkg::wide_t cut_end, lo_size_w, s1_w, p1_w;
  abss_pkg::wide_t cut_start, hi_size_w, s2_w;
  logic            lo_v, hi_v;

  // extend to exact width
  assign p0_w   = abss_pkg::wide_t'(p0);
  assign s0_w   = abss_pkg::wide_t'({1'b0, s0});
  assign bmin_w = abss_pkg::wide_t'(b_min);
  assign end_w  = p0_w + s0_w;
  assign bend_w = bmin_w + abss_pkg::wide_t'({1'b0, b_size});

  // cut the part below the excluded minimum
  assign lo_v      = (s0 != '0) && (p0_w < bmin_w);
  assign cut_end   = (bmin_w < end_w) ? bmin_w : end_w;
  assign lo_size_w = cut_end - p0_w;
  assign s1_w      = lo_v ? (end_w - cut_end) : s0_w;
  assign p1_w      = lo_v ? cut_end : p0_w;

  // cut the part above the excluded maximum
  assign hi_v      = (s1_w != '0) && (end_w > bend_w);
  assign cut_start = (bend_w > p1_w) ? bend_w : p1_w;
  assign hi_size_w = end_w - cut_start;
  assign s2_w      = hi_v ? (cut_start - p1_w) : s1_w;

  assign cut.lo_v     = lo_v;
  assign cut.lo_size  = lo_size_w[abss_pkg::SIZE_W-1:0];
  assign cut.hi_v     = hi_v;
  assign cut.hi_min   = cut_start[abss_pkg::COORD_W-1:0];
  assign cut.hi_size  = hi_size_w[abss_pkg::SIZE_W-1:0];
  assign cut.fin_min  = p1_w[abss_pkg::COORD_W-1:0];
  assign cut.fin_size = s2_w[abss_pkg::SIZE_W-1:0];
  assign cut.stop     = (s2_w == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/abss_split.sv
`default_nettype none

module abss_split (
  input  abss_pkg::box_t                            a_box,
  input  abss_pkg::box_t                            b_box,
  output abss_pkg::piece_t [abss_pkg::NUM_SLOTS-1:0] pieces,
  output logic [abss_pkg::NUM_SLOTS-1:0]             mask
);

  abss_pkg::axis_cut_t cut [abss_pkg::AXES];

  // every axis cuts independently on its own coordinates
  for (genvar g = 0; g < abss_pkg::AXES; g++) begin : g_axis
    abss_axis_cut u_cut (
      .p0     ($signed(a_box.corner[g])),
      .s0     (a_box.ext[g]),
      .b_min  ($signed(b_box.corner[g])),
      .b_size (b_box.ext[g]),
      .cut    (cut[g])
    );
  end

  // assemble pieces in z, y, x order; earlier axes carry their shrunk box
  always_comb begin
    abss_pkg::box_t lo_box;
    abss_pkg::box_t hi_box;
    logic           en;
    pieces = '0;
    mask   = '0;
    en     = 1'b1;
    for (int ax = abss_pkg::AXES - 1; ax >= 0; ax--) begin
      lo_box = a_box;
      for (int k = 0; k < abss_pkg::AXES; k++) begin
        if (k > ax) begin
          lo_box.corner[k] = cut[k].fin_min;
          lo_box.ext[k]    = cut[k].fin_size;
        end
      end
      hi_box            = lo_box;
      lo_box.ext[ax]    = cut[ax].lo_size;
      hi_box.corner[ax] = cut[ax].hi_min;
      hi_box.ext[ax]    = cut[ax].hi_size;
      pieces[2*(abss_pkg::AXES-1-ax)]     = '{box: lo_box, valid: 1'b1};
      pieces[2*(abss_pkg::AXES-1-ax) + 1] = '{box: hi_box, valid: 1'b1};
      mask[2*(abss_pkg::AXES-1-ax)]       = en && cut[ax].lo_v;
      mask[2*(abss_pkg::AXES-1-ax) + 1]   = en && cut[ax].hi_v;
      en = en && !cut[ax].stop;
    end
    // no piece: send one empty result
    if (mask == '0) begin
      pieces[0] = '0;
      mask[0]   = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/abss_emit.sv
`default_nettype none

module abss_emit (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       load_valid,
  input  abss_pkg::piece_t [abss_pkg::NUM_SLOTS-1:0] pieces_in,
  input  logic [abss_pkg::NUM_SLOTS-1:0]             mask_in,
  input  logic                                       out_stall,
  output abss_pkg::piece_t                           out_piece,
  output logic                                       out_last,
  output logic                                       out_valid,
  output abss_pkg::emit_stat_t                       stat
);

  abss_pkg::piece_t                pieces_r [abss_pkg::NUM_SLOTS];
  logic [abss_pkg::NUM_SLOTS-1:0]  mask_r, mask_nxt;
  abss_pkg::piece_t                out_piece_r;
  logic                            out_last_r, out_valid_r, out_valid_nxt;
  logic [abss_pkg::SLOT_W-1:0]     sel;
  logic [abss_pkg::NUM_SLOTS-1:0]  pick_oh, remaining;
  logic                            out_free, pop, take;

  // pick the lowest pending slot
  always_comb begin
    sel     = '0;
    pick_oh = '0;
    for (int i = abss_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel     = abss_pkg::SLOT_W'(i);
        pick_oh = abss_pkg::NUM_SLOTS'(1) << i;
      end
    end
  end

  assign remaining = mask_r & ~pick_oh;
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (mask_r != '0) && out_free;
  assign take      = (mask_r == '0) || (pop && (remaining == '0));

  // advance the pending mask, reload it behind the last piece
  always_comb begin
    mask_nxt = mask_r;
    if (take && load_valid) begin
      mask_nxt = mask_in;
    end else if (take) begin
      mask_nxt = '0;
    end else if (pop) begin
      mask_nxt = remaining;
    end
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold piece data; load the output register on each transfer slot
  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      for (int i = 0; i < abss_pkg::NUM_SLOTS; i++) begin
        pieces_r[i] <= pieces_in[i];
      end
    end
    if (pop) begin
      out_piece_r <= pieces_r[sel];
      out_last_r  <= (remaining == '0);
    end
  end

  assign out_piece = out_piece_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;
  assign stat.take = take;
  assign stat.busy = (mask_r != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/aligned_box_subtract_split_core.sv
// Box subtraction A minus B for axis-aligned 3D boxes in signed fixed point.
// Input channel (in_valid / in_stall): one box pair per transfer, each box a
// minimum corner and a non-negative size per axis.
// Result channel (out_valid / out_stall): one piece per transfer, covering
// A minus B without overlap, cut on z first, then y, then x. out_last_piece
// marks the final result of a pair; a pair that leaves nothing yields one
// result with out_piece_valid low and all coordinates zero.
// The first result of a pair passes the input register, then the piece buffer,
// then the output register.
// Throughput: one result per cycle while out_stall is low; a pair yields 1 to 6
// results, and the next pair enters the piece buffer in the cycle its
// predecessor's last piece moves to the output register.
// A stalled receiver holds the output register; the buffer and input register
// then fill and in_stall rises. Reset empties all three stages; no pair is kept.
`default_nettype none

module aligned_box_subtract_split_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_a_min_x,
  input  logic signed [31:0] in_a_min_y,
  input  logic signed [31:0] in_a_min_z,
  input  logic [30:0]        in_a_size_x,
  input  logic [30:0]        in_a_size_y,
  input  logic [30:0]        in_a_size_z,
  input  logic signed [31:0] in_b_min_x,
  input  logic signed [31:0] in_b_min_y,
  input  logic signed [31:0] in_b_min_z,
  input  logic [30:0]        in_b_size_x,
  input  logic [30:0]        in_b_size_y,
  input  logic [30:0]        in_b_size_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_piece_min_x,
  output logic signed [31:0] out_piece_min_y,
  output logic signed [31:0] out_piece_min_z,
  output logic [30:0]        out_piece_size_x,
  output logic [30:0]        out_piece_size_y,
  output logic [30:0]        out_piece_size_z,
  output logic               out_piece_valid,
  output logic               out_last_piece
);

  abss_pkg::box_t                            a_in, b_in, a_r, b_r;
  logic                                      in_valid_r, in_valid_nxt;
  abss_pkg::piece_t [abss_pkg::NUM_SLOTS-1:0] pieces;
  logic [abss_pkg::NUM_SLOTS-1:0]             mask;
  abss_pkg::emit_stat_t                      stat;
  abss_pkg::piece_t                          out_piece;
  logic                                      s1_take;

  // gather input ports into boxes
  assign a_in.corner = {in_a_min_z, in_a_min_y, in_a_min_x};
  assign a_in.ext    = {in_a_size_z, in_a_size_y, in_a_size_x};
  assign b_in.corner = {in_b_min_z, in_b_min_y, in_b_min_x};
  assign b_in.ext    = {in_b_size_z, in_b_size_y, in_b_size_x};

  // input register moves on when the piece buffer takes it
  assign s1_take      = !in_valid_r || stat.take;
  assign in_stall     = !s1_take;
  assign in_valid_nxt = s1_take ? in_valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      a_r <= a_in;
      b_r <= b_in;
    end
  end

  abss_split u_split (
    .a_box  (a_r),
    .b_box  (b_r),
    .pieces (pieces),
    .mask   (mask)
  );

  abss_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid_r),
    .pieces_in  (pieces),
    .mask_in    (mask),
    .out_stall  (out_stall),
    .out_piece  (out_piece),
    .out_last   (out_last_piece),
    .out_valid  (out_valid),
    .stat       (stat)
  );

  // spread the output piece onto the ports
  assign out_piece_min_x  = $signed(out_piece.box.corner[0]);
  assign out_piece_min_y  = $signed(out_piece.box.corner[1]);
  assign out_piece_min_z  = $signed(out_piece.box.corner[2]);
  assign out_piece_size_x = out_piece.box.ext[0];
  assign out_piece_size_y = out_piece.box.ext[1];
  assign out_piece_size_z = out_piece.box.ext[2];
  assign out_piece_valid  = out_piece.valid;

`ifndef SYNTHESIS
  // an empty result always closes its pair
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_piece_valid |-> out_last_piece)
    else $error("empty result without last marker");

  // an empty result carries zero sizes
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_piece_valid |->
      (out_piece_size_x == '0) && (out_piece_size_y == '0) && (out_piece_size_z == '0))
    else $error("empty result with nonzero size");

  // a held input register keeps its pair
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !s1_take |=> in_valid_r && $stable(a_r) && $stable(b_r))
    else $error("input register lost a held pair");

  // an idle piece buffer always takes the next pair
  a_idle_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> stat.take)
    else $error("idle piece buffer refused a pair");
`endif

endmodule

`default_nettype wire
